/* hdl/ffa_pkg.sv */
// Shared types and constants for the first-fit resource map allocator.
package ffa_pkg;

  // Fixed field widths of the request and result items.
  localparam int SIZE_W     = 14;
  localparam int ADDR_W     = 19;
  localparam int PAGES_W    = 7;
  localparam int LIVE_W     = 9;
  localparam int PTR_BYTES  = 8;
  localparam int LIVE_MAX   = 511;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  // Request kinds carried in tuser.
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TOO_LARGE  = 2'd1,
    ST_NO_PAGE    = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_t;

  // Commands broadcast to the segment cells.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_UPDATE,
    CMD_DROP,
    CMD_INSERT,
    CMD_APPEND
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
  } cell_ctl_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_HIT,
    S_NEWPG,
    S_FIND,
    S_INSERT,
    S_LREAD,
    S_LUSE,
    S_TRIM_RD,
    S_TRIM_CHK,
    S_DROP,
    S_DONE
  } state_t;

endpackage

/* hdl/ffa_cell.sv */
// One entry of the sorted free-segment chain.
module ffa_cell
  import ffa_pkg::*;
#(
  parameter int IDX    = 0,
  parameter int BASE_W = 19,
  parameter int LEN_W  = 14,
  parameter int CNT_W  = 7
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [CNT_W-1:0]  sel_idx,
  input  logic [CNT_W-1:0]  count,
  input  logic [BASE_W-1:0] key,
  input  logic [BASE_W-1:0] new_base,
  input  logic [LEN_W-1:0]  new_len,
  input  logic              left_gt,
  input  logic [BASE_W-1:0] left_base,
  input  logic [LEN_W-1:0]  left_len,
  input  logic [BASE_W-1:0] right_base,
  input  logic [LEN_W-1:0]  right_len,
  output logic [BASE_W-1:0] base,
  output logic [LEN_W-1:0]  len,
  output logic              gt
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic valid;

  // A valid entry whose base lies above the insert key.
  assign valid = MY_IDX < count;
  assign gt    = valid && (base > key);

  // Entry update: shift from a neighbor, load new data, or hold.
  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CMD_UPDATE: begin
        if (MY_IDX == sel_idx) begin
          base <= new_base;
          len  <= new_len;
        end
      end
      CMD_DROP: begin
        if (MY_IDX >= sel_idx) begin
          base <= right_base;
          len  <= right_len;
        end
      end
      CMD_INSERT: begin
        if (left_gt) begin
          base <= left_base;
          len  <= left_len;
        end else if (gt || MY_IDX == count) begin
          base <= new_base;
          len  <= new_len;
        end
      end
      CMD_APPEND: begin
        if (MY_IDX == count) begin
          base <= new_base;
          len  <= new_len;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* hdl/first_fit_resource_map_allocator_core.sv */
// First-fit resource map allocator: request stream in, one result per request out.
//
// Requests arrive on the s_ channel (tuser = opcode, tdata = size and address)
// and each produces exactly one result transfer on the m_ channel.
// Free segments live in a chain of cells sorted by address; per-page live
// block counts live in a small single-port memory.
// An allocate scans the chain one cell per cycle. A free walks the open pages
// one per cycle to find its page, inserts the freed segment, then releases
// empty trailing pages, dropping one segment per cycle.
// One request is worked on at a time; a new request is taken as soon as the
// previous one has reached the output register, even while that result waits.
// If the receiver stalls, the finished result holds in the output register
// and the sequencer waits before loading the next one.
// Reset empties the segment table and closes all pages at once; no clearing
// pass is needed.
module first_fit_resource_map_allocator_core
  import ffa_pkg::*;
#(
  parameter int PAGE_BYTES   = 8192,
  parameter int MAX_PAGES    = 64,
  parameter int TABLE_DEPTH  = 64,
  parameter int MIN_BLOCK    = 32,
  parameter int HEADER_BYTES = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // req_size[13:0], free_addr[32:14], zero fill
  input  logic                  s_tuser,   // opcode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // block_addr[18:0], status[20:19], pages_open[27:21]
);

  localparam int SPAN_W = $clog2(MAX_PAGES * PAGE_BYTES + 1);
  localparam int BASE_W = (SPAN_W > ADDR_W) ? SPAN_W : ADDR_W;
  localparam int PL_W   = $clog2(PAGE_BYTES + 1);
  localparam int LEN_W  = (PL_W > SIZE_W) ? PL_W : SIZE_W;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int PT_W   = $clog2(MAX_PAGES + 1);
  localparam int PG_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int SPAN   = (HEADER_BYTES >= PAGE_BYTES) ? 0 : PAGE_BYTES - HEADER_BYTES;
  localparam logic [LEN_W-1:0]  SPAN_L  = LEN_W'(SPAN);
  localparam logic [LEN_W-1:0]  MIN_L   = LEN_W'(MIN_BLOCK);
  localparam logic [BASE_W:0]   PAGE_X  = (BASE_W + 1)'(PAGE_BYTES);
  localparam logic [BASE_W-1:0] PAGE_B  = BASE_W'(PAGE_BYTES);
  localparam logic [BASE_W-1:0] HDR_B   = BASE_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(TABLE_DEPTH);
  localparam logic [PT_W-1:0]   MAXP_C  = PT_W'(MAX_PAGES);
  localparam logic [LIVE_W-1:0] LIVE_TOP = LIVE_W'(LIVE_MAX);

  // Control and request registers.
  state_t              state, state_next;
  op_t                 op;
  logic [SIZE_W-1:0]   sz;
  logic [SIZE_W-1:0]   need;
  logic [BASE_W-1:0]   key;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    idx;
  logic [PT_W-1:0]     pt;
  logic [BASE_W-1:0]   top_lo;
  logic [PT_W-1:0]     pg;
  logic [BASE_W-1:0]   lo;
  logic [BASE_W-1:0]   res_addr;
  status_t             res_status;
  logic [ADDR_W-1:0]   out_addr;
  status_t             out_status;
  logic [PAGES_W-1:0]  out_pages;

  // Live block counters per page.
  logic [LIVE_W-1:0]   live_mem [MAX_PAGES];
  logic [LIVE_W-1:0]   live_q;
  logic                live_re;
  logic                live_we;
  logic [PG_W-1:0]     live_addr;
  logic [LIVE_W-1:0]   live_wdata;

  // Cell chain signals.
  cell_ctl_t           ctl;
  logic [CNT_W-1:0]    sel_idx;
  logic [BASE_W-1:0]   new_base;
  logic [LEN_W-1:0]    new_len;
  logic [BASE_W-1:0]   cell_base [TABLE_DEPTH];
  logic [LEN_W-1:0]    cell_len  [TABLE_DEPTH];
  logic                cell_gt   [TABLE_DEPTH];
  logic [BASE_W-1:0]   rd_base;
  logic [LEN_W-1:0]    rd_len;
  logic [CNT_W-1:0]    rd_idx;

  // Derived request values.
  logic                too_large;
  logic [SIZE_W-1:0]   in_need;
  logic [LEN_W-1:0]    fresh_rem;
  logic [LEN_W-1:0]    hit_rem;
  logic                out_free;

  assign too_large = (32'(s_tdata[SIZE_W-1:0]) + 32'(PTR_BYTES)) > 32'(PAGE_BYTES);
  assign in_need   = (32'(s_tdata[SIZE_W-1:0]) < 32'(MIN_BLOCK)) ?
                     SIZE_W'(MIN_BLOCK) : s_tdata[SIZE_W-1:0];
  assign fresh_rem = SPAN_L - LEN_W'(need);
  assign hit_rem   = rd_len - LEN_W'(need);
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE);

  // Chain of segment cells.
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    ffa_cell #(
      .IDX    (k),
      .BASE_W (BASE_W),
      .LEN_W  (LEN_W),
      .CNT_W  (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .sel_idx    (sel_idx),
      .count      (count),
      .key        (key),
      .new_base   (new_base),
      .new_len    (new_len),
      .left_gt    ((k == 0) ? 1'b0 : cell_gt[(k == 0) ? 0 : k - 1]),
      .left_base  (cell_base[(k == 0) ? 0 : k - 1]),
      .left_len   (cell_len[(k == 0) ? 0 : k - 1]),
      .right_base (cell_base[(k == TABLE_DEPTH - 1) ? k : k + 1]),
      .right_len  (cell_len[(k == TABLE_DEPTH - 1) ? k : k + 1]),
      .base       (cell_base[k]),
      .len        (cell_len[k]),
      .gt         (cell_gt[k])
    );
  end

  // Tap of the cell picked by the scan or trim position.
  always_comb begin
    rd_base = '0;
    rd_len  = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (CNT_W'(k) == rd_idx) begin
        rd_base = cell_base[k];
        rd_len  = cell_len[k];
      end
    end
  end

  assign rd_idx = (state == S_DROP) ? count - CNT_W'(1) : idx;

  // Live counter memory with registered read.
  always_ff @(posedge clk) begin
    if (live_we) begin
      live_mem[live_addr] <= live_wdata;
    end
    if (live_re) begin
      live_q <= live_mem[live_addr];
    end
  end

  // State register and request bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      pt       <= '0;
      top_lo   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      // The output register fills from the done state and empties on a transfer.
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op         <= op_t'(s_tuser);
            sz         <= s_tdata[SIZE_W-1:0];
            need       <= in_need;
            key        <= BASE_W'(s_tdata[SIZE_W +: ADDR_W]);
            idx        <= '0;
            pg         <= '0;
            lo         <= '0;
            res_addr   <= '0;
            res_status <= too_large && s_tuser == OP_ALLOC ? ST_TOO_LARGE : ST_OK;
          end
        end
        S_SCAN: begin
          if (idx != count && rd_len < LEN_W'(need)) begin
            idx <= idx + CNT_W'(1);
          end
        end
        S_HIT: begin
          res_addr <= rd_base;
          key      <= rd_base;
          if (hit_rem < MIN_L) begin
            count <= count - CNT_W'(1);
          end
        end
        S_NEWPG: begin
          if (32'(need) > SPAN) begin
            res_status <= ST_TOO_LARGE;
          end else if (pt >= MAXP_C) begin
            res_status <= ST_NO_PAGE;
          end else if (fresh_rem >= MIN_L && count >= DEPTH_C) begin
            res_status <= ST_TABLE_FULL;
          end else begin
            res_addr <= top_lo + HDR_B;
            pt       <= pt + PT_W'(1);
            top_lo   <= top_lo + PAGE_B;
            if (fresh_rem >= MIN_L) begin
              count <= count + CNT_W'(1);
            end
          end
        end
        S_FIND: begin
          if (pg != pt && {1'b0, key} >= {1'b0, lo} + PAGE_X) begin
            pg <= pg + PT_W'(1);
            lo <= lo + PAGE_B;
          end else if (pg != pt && op == OP_FREE && count >= DEPTH_C) begin
            res_status <= ST_TABLE_FULL;
          end
        end
        S_INSERT: begin
          count <= count + CNT_W'(1);
        end
        S_DROP: begin
          if (count != '0 && rd_base >= top_lo - PAGE_B) begin
            count <= count - CNT_W'(1);
          end else begin
            pt     <= pt - PT_W'(1);
            top_lo <= top_lo - PAGE_B;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_addr   <= ADDR_W'(res_addr);
            out_status <= res_status;
            out_pages  <= PAGES_W'(pt);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Next state, cell commands and memory controls.
  always_comb begin
    state_next = state;
    ctl.cmd    = CMD_NONE;
    sel_idx    = idx;
    new_base   = key;
    new_len    = LEN_W'(sz);
    live_re    = 1'b0;
    live_we    = 1'b0;
    live_addr  = pg[PG_W-1:0];
    live_wdata = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == OP_FREE) begin
            state_next = S_FIND;
          end else if (too_large) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx == count) begin
          state_next = S_NEWPG;
        end else if (rd_len >= LEN_W'(need)) begin
          state_next = S_HIT;
        end
      end
      S_HIT: begin
        new_base   = rd_base + BASE_W'(need);
        new_len    = hit_rem;
        ctl.cmd    = (hit_rem < MIN_L) ? CMD_DROP : CMD_UPDATE;
        state_next = S_FIND;
      end
      S_NEWPG: begin
        state_next = S_DONE;
        new_base   = top_lo + HDR_B + BASE_W'(need);
        new_len    = fresh_rem;
        live_addr  = pt[PG_W-1:0];
        live_wdata = LIVE_W'(1);
        if (32'(need) <= SPAN && pt < MAXP_C &&
            !(fresh_rem >= MIN_L && count >= DEPTH_C)) begin
          live_we = 1'b1;
          if (fresh_rem >= MIN_L) begin
            ctl.cmd = CMD_APPEND;
          end
        end
      end
      S_FIND: begin
        if (pg == pt) begin
          state_next = S_DONE;
        end else if ({1'b0, key} < {1'b0, lo} + PAGE_X) begin
          if (op == OP_ALLOC) begin
            state_next = S_LREAD;
          end else if (count >= DEPTH_C) begin
            state_next = S_DONE;
          end else begin
            state_next = S_INSERT;
          end
        end
      end
      S_INSERT: begin
        ctl.cmd    = CMD_INSERT;
        state_next = S_LREAD;
      end
      S_LREAD: begin
        live_re    = 1'b1;
        state_next = S_LUSE;
      end
      S_LUSE: begin
        live_we = 1'b1;
        if (op == OP_ALLOC) begin
          live_wdata = (live_q < LIVE_TOP) ? live_q + LIVE_W'(1) : live_q;
          state_next = S_DONE;
        end else begin
          live_wdata = (live_q != '0) ? live_q - LIVE_W'(1) : live_q;
          state_next = S_TRIM_RD;
        end
      end
      S_TRIM_RD: begin
        live_addr = PG_W'(pt - PT_W'(1));
        if (pt == '0) begin
          state_next = S_DONE;
        end else begin
          live_re    = 1'b1;
          state_next = S_TRIM_CHK;
        end
      end
      S_TRIM_CHK: begin
        state_next = (live_q == '0) ? S_DROP : S_DONE;
      end
      S_DROP: begin
        if (!(count != '0 && rd_base >= top_lo - PAGE_B)) begin
          state_next = S_TRIM_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign m_tdata = {{(OUT_DATA_W - ADDR_W - 2 - PAGES_W){1'b0}},
                    out_pages, out_status, out_addr};

  // The segment table never holds more entries than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("segment count beyond table depth");

  // Open pages never exceed the page limit, and the page top tracks them.
  a_page_bound: assert property (@(posedge clk) disable iff (rst)
    pt <= MAXP_C && 32'(top_lo) == 32'(pt) * 32'(PAGE_BYTES))
    else $error("page count or page top out of step");

  // A finished request reaches the output on the next cycle.
  a_done_out: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_free |=> m_tvalid && state == S_IDLE)
    else $error("finished result not presented");

  // Only one request is in work: no transfer is taken outside idle.
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !s_tready)
    else $error("request taken while busy");

endmodule
